### src/dsa_pkg.sv
// shared types and constants of the decimal scaled add unit
// widths, pipeline depth and the power-of-ten limit table; no dependencies
package dsa_pkg;

    localparam int VALUE_BITS    = 256;
    localparam int PRECISION_CAP = 65;
    localparam int CFG_W         = 7;
    localparam int IDX_W         = 2;
    localparam int WORD_W        = 64;
    localparam int K_MAX         = (1 << CFG_W) - 1;
    // each scaler stage multiplies by up to a thousand
    localparam int DIGITS_PER_STAGE = 3;
    localparam int N_SCALE       = (K_MAX + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE;
    localparam int LATENCY       = N_SCALE + 4;
    localparam int CMP_W         = (VALUE_BITS + 1 > 256) ? VALUE_BITS + 1 : 256;
    localparam int PREC_W        = $clog2(PRECISION_CAP + 1);

    localparam logic [IDX_W-1:0] REG_LEFT_PREC  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_LEFT_SCALE = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_RIGHT_PREC = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_RIGHT_SCALE = IDX_W'(3);

    typedef logic [CMP_W-1:0] t_pow_tab [0:PRECISION_CAP];

    typedef struct packed {
        logic                    v;
        logic                    nul;
        logic                    ovf;
        logic [CFG_W-1:0]        krem;
        logic [PREC_W-1:0]       prec;
        logic [VALUE_BITS-1:0]   x;
        logic [VALUE_BITS-1:0]   y;
    } t_stage;

    function automatic t_pow_tab pow10_table();
        t_pow_tab tab;
        tab[0] = CMP_W'(1);
        for (int p = 1; p <= PRECISION_CAP; p++) begin
            tab[p] = (tab[p-1] << 3) + (tab[p-1] << 1);
        end
        return tab;
    endfunction

    localparam t_pow_tab POW10 = pow10_table();

endpackage

### src/decimal_scaled_add_unit.sv
// top level of the decimal scaled add unit: operand alignment pipeline,
// wide add, magnitude check against the result precision; uses dsa_pkg
//
// usage: pulse start with both operands and null flags; busy is always low,
// so a request is taken every cycle. each request yields exactly one result,
// shown for one cycle with o_valid high, in request order.
// pipeline from the accepting edge to the result cycle: input register,
// 43 scaler stages, add, magnitude, compare/output.
// throughput: one request per cycle, set by the fully pipelined scaler chain,
// where each stage multiplies the smaller-scale operand by 1, 10, 100 or 1000.
// precision and scale registers are captured with each request at the input
// register; write them only when no request is in flight.
// reset (synchronous, active low) clears the valid bits and sets the
// registers to precision 10, scale 0 on both sides.
// the receiver cannot stall; results are never held or repeated.
module decimal_scaled_add_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [dsa_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [dsa_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [63:0]                   i_left_word0,
    input  logic [63:0]                   i_left_word1,
    input  logic [63:0]                   i_left_word2,
    input  logic signed [63:0]            i_left_word3,
    input  logic [63:0]                   i_right_word0,
    input  logic [63:0]                   i_right_word1,
    input  logic [63:0]                   i_right_word2,
    input  logic signed [63:0]            i_right_word3,
    input  logic                          i_left_is_null,
    input  logic                          i_right_is_null,
    output logic                          o_valid,
    output logic [63:0]                   o_sum_word0,
    output logic [63:0]                   o_sum_word1,
    output logic [63:0]                   o_sum_word2,
    output logic signed [63:0]            o_sum_word3,
    output logic                          o_sum_is_null,
    output logic                          o_overflowed
);
    import dsa_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam int XW = VB + 10;

    logic [CFG_W-1:0] r_lp, r_ls, r_rp, r_rs;

    t_stage r_st [0:N_SCALE];
    t_stage n_st [0:N_SCALE];

    logic                r_s_v, r_s_nul, r_s_ovf;
    logic [PREC_W-1:0]   r_s_prec;
    logic signed [VB:0]  r_sum;
    logic                r_m_v, r_m_nul, r_m_ovf;
    logic [PREC_W-1:0]   r_m_prec;
    logic [VB-1:0]       r_m_wrap;
    logic [VB:0]         r_mag;
    logic                r_o_v, r_o_nul, r_o_ovf;
    logic [VB-1:0]       r_o_sum;

    logic [255:0]        left_all, right_all, sum_ext;
    logic signed [9:0]   lint, rint, res_int, prec_full;
    logic [CFG_W-1:0]    res_scale;
    logic signed [VB:0]  n_sum;
    logic [VB:0]         n_mag;

    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp <= CFG_W'(10);
            r_ls <= '0;
            r_rp <= CFG_W'(10);
            r_rs <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LEFT_PREC:   r_lp <= i_cfg_data;
                REG_LEFT_SCALE:  r_ls <= i_cfg_data;
                REG_RIGHT_PREC:  r_rp <= i_cfg_data;
                REG_RIGHT_SCALE: r_rs <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign left_all  = {i_left_word3, i_left_word2, i_left_word1, i_left_word0};
    assign right_all = {i_right_word3, i_right_word2, i_right_word1, i_right_word0};

    // input stage: pick the operand to scale, work out the result precision
    always_comb begin
        logic signed [XW-1:0] w;
        logic signed [XW-1:0] p;
        lint      = $signed({3'b000, r_lp}) - $signed({3'b000, r_ls});
        rint      = $signed({3'b000, r_rp}) - $signed({3'b000, r_rs});
        res_int   = (lint > rint) ? lint : rint;
        res_scale = (r_ls > r_rs) ? r_ls : r_rs;
        prec_full = $signed({3'b000, res_scale}) + res_int + 10'sd1;
        n_st[0].v   = start;
        n_st[0].nul = i_left_is_null | i_right_is_null;
        n_st[0].ovf = 1'b0;
        if (prec_full > $signed(10'(PRECISION_CAP))) begin
            n_st[0].prec = PREC_W'(PRECISION_CAP);
        end else if (prec_full < 10'sd1) begin
            n_st[0].prec = PREC_W'(1);
        end else begin
            n_st[0].prec = prec_full[PREC_W-1:0];
        end
        if (r_ls >= r_rs) begin
            n_st[0].x    = right_all[VB-1:0];
            n_st[0].y    = left_all[VB-1:0];
            n_st[0].krem = r_ls - r_rs;
        end else begin
            n_st[0].x    = left_all[VB-1:0];
            n_st[0].y    = right_all[VB-1:0];
            n_st[0].krem = r_rs - r_ls;
        end

        // scaler stages: multiply by 10^d, d up to three, flag leaving the signed range
        for (int i = 1; i <= N_SCALE; i++) begin
            w = XW'(signed'(r_st[i-1].x));
            n_st[i] = r_st[i-1];
            if (r_st[i-1].krem >= CFG_W'(3)) begin
                p = (w <<< 10) - (w <<< 4) - (w <<< 3);
                n_st[i].krem = r_st[i-1].krem - CFG_W'(3);
            end else if (r_st[i-1].krem == CFG_W'(2)) begin
                p = (w <<< 6) + (w <<< 5) + (w <<< 2);
                n_st[i].krem = '0;
            end else if (r_st[i-1].krem == CFG_W'(1)) begin
                p = (w <<< 3) + (w <<< 1);
                n_st[i].krem = '0;
            end else begin
                p = w;
            end
            n_st[i].x = p[VB-1:0];
            if (p != XW'(signed'(p[VB-1:0]))) begin
                n_st[i].ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        t_stage stg;
        for (int i = 0; i <= N_SCALE; i++) begin
            stg = n_st[i];
            if (!i_rst_n) begin
                stg.v = 1'b0;
            end
            r_st[i] <= stg;
        end
    end

    assign n_sum = (VB+1)'(signed'(r_st[N_SCALE].x)) + (VB+1)'(signed'(r_st[N_SCALE].y));
    assign n_mag = r_sum[VB] ? (~r_sum + (VB+1)'(1)) : r_sum;

    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_s_nul  <= r_st[N_SCALE].nul;
        r_s_ovf  <= r_st[N_SCALE].ovf;
        r_s_prec <= r_st[N_SCALE].prec;
        r_mag    <= n_mag;
        r_m_wrap <= r_sum[VB-1:0];
        r_m_nul  <= r_s_nul;
        r_m_ovf  <= r_s_ovf | (r_sum[VB] != r_sum[VB-1]);
        r_m_prec <= r_s_prec;
        r_o_nul  <= r_m_nul;
        r_o_sum  <= r_m_nul ? '0 : r_m_wrap;
        r_o_ovf  <= !r_m_nul && (r_m_ovf || (CMP_W'(r_mag) >= POW10[r_m_prec]));
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
            r_m_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            r_s_v <= r_st[N_SCALE].v;
            r_m_v <= r_s_v;
            r_o_v <= r_m_v;
        end
    end

    assign sum_ext       = 256'(signed'(r_o_sum));
    assign o_valid       = r_o_v;
    assign o_sum_word0   = sum_ext[63:0];
    assign o_sum_word1   = sum_ext[127:64];
    assign o_sum_word2   = sum_ext[191:128];
    assign o_sum_word3   = sum_ext[255:192];
    assign o_sum_is_null = r_o_nul;
    assign o_overflowed  = r_o_ovf;

`ifndef SYNTHESIS
    a_null_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sum_is_null |-> !o_overflowed)
        else $error("null result carries overflow");
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_valid)
        else $error("request without result");
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && $past(start) |-> !busy)
        else $error("back to back request refused");
`endif

endmodule
